// ----- rtl/obf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obf_pkg: shared types and constants of the overwritable byte fifo
// op codes, register indexes, command and result structs
// ----------------------------------------------------------------------------
package obf_pkg;

	localparam int DEPTH_MAX_DEF = 256;

	// indices run over 0 .. 2*depth-1 and depth is at most 511
	localparam int IDX_W = 10;
	localparam int DEPTH_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int DEPTH_RST = 256;

	localparam logic [CFG_IDX_W-1:0] CFG_FIFO_DEPTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE_MODE = 2'd1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_in;
	} in_t;

	typedef struct packed {
		logic               ok;
		logic [7:0]         data_out;
		logic [DEPTH_W-1:0] fill_count;
		logic               overflow_fixed;
	} out_t;

endpackage

// ----- rtl/overwritable_byte_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwritable_byte_fifo: byte fifo with visible overflow and overwrite mode
// write, read, peek and clear commands on doubled-range indices
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  command   start in, busy out             cmd (op, data_in)
//  result    done strobe out, one cycle     result (ok, data_out, fill_count,
//                                           overflow_fixed)
//  config    cfg_valid in, cfg_ready out    cfg_index, cfg_data
//
//  one command per cycle; after the transfer its result passes through
//  the command register first, then a result register that also holds the store read
//  busy stays low, cfg_ready stays high
//  reset: indices zero, depth 256 (at most DEPTH_MAX), overwrite off; byte store not cleared
//  the result side cannot stall: done is a one-cycle strobe
// ----------------------------------------------------------------------------
module overwritable_byte_fifo #(
	parameter int DEPTH_MAX = obf_pkg::DEPTH_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  obf_pkg::in_t                    cmd,
	output logic                            done,
	output obf_pkg::out_t                   result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [obf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [obf_pkg::DEPTH_W-1:0]     cfg_data
);

	localparam int IW = obf_pkg::IDX_W;
	localparam int DW = obf_pkg::DEPTH_W;
	localparam int DCAP = (DEPTH_MAX < 511) ? DEPTH_MAX : 511;
	localparam int DRST = (obf_pkg::DEPTH_RST < DCAP) ? obf_pkg::DEPTH_RST : DCAP;
	localparam int AW = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
	localparam int SLW = (AW < IW) ? AW : IW;

	// configuration
	logic [DW-1:0] depth_q;
	logic          overwrite_q;
	logic          cfg_fire;

	// index state
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;

	// stage 1: registered command
	logic          valid_s1;
	obf_pkg::in_t  cmd_s1;

	// stage 2: result
	logic          valid_s2;
	logic          ok_s2;
	logic          rdok_s2;
	logic          fixed_s2;
	logic [DW-1:0] fill_s2;
	logic [7:0]    rdata_s2;

	// byte store
	logic [7:0]    mem [DEPTH_MAX];

	// stage 1 logic
	logic [IW-1:0] dx;
	logic [IW-1:0] two_d;
	logic [IW-1:0] cnt;
	logic [IW-1:0] wr_base;
	logic [IW-1:0] rd_fix;
	logic [IW-1:0] wr_new;
	logic [IW-1:0] rd_new;
	logic [IW-1:0] fill_new;
	logic [IW-1:0] slot;
	logic          ok_c;
	logic          fixed_c;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;

	function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] v, input logic [IW-1:0] m);
		logic [IW:0] mx;
		mx = {1'b0, m};
		return (v >= mx) ? IW'(v - mx) : IW'(v);
	endfunction

	function automatic logic [IW-1:0] fill_of(input logic [IW-1:0] w, input logic [IW-1:0] r,
			input logic [IW-1:0] m);
		return (w >= r) ? (w - r) : (w + m - r);
	endfunction

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;

	always_comb begin
		dx = {1'b0, depth_q};
		two_d = {depth_q, 1'b0};
		cnt = fill_of(wr_q, rd_q, two_d);
		wr_base = wr_q;
		rd_fix = rd_q;
		wr_new = wr_q;
		rd_new = rd_q;
		ok_c = 1'b0;
		fixed_c = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		case (cmd_s1.op)
			obf_pkg::OP_WRITE: begin
				if (cnt < dx || overwrite_q) begin
					// double overflow: land the write just behind the read side
					if (overwrite_q && cnt == two_d - IW'(1)) begin
						wr_base = wrap_idx({1'b0, rd_q} + {1'b0, dx} - (IW+1)'(1), two_d);
					end
					wr_new = wrap_idx({1'b0, wr_base} + (IW+1)'(1), two_d);
					ok_c = 1'b1;
					mem_we = valid_s1;
				end
			end
			obf_pkg::OP_READ, obf_pkg::OP_PEEK: begin
				if (cnt != '0) begin
					if (cnt > dx) begin
						rd_fix = (wr_q >= dx) ? (wr_q - dx) : (wr_q + dx);
						fixed_c = 1'b1;
					end
					rd_new = (cmd_s1.op == obf_pkg::OP_READ)
						? wrap_idx({1'b0, rd_fix} + (IW+1)'(1), two_d) : rd_fix;
					ok_c = 1'b1;
					mem_re = valid_s1;
				end
			end
			obf_pkg::OP_CLEAR: begin
				wr_new = '0;
				rd_new = '0;
				ok_c = 1'b1;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
		fill_new = fill_of(wr_new, rd_new, two_d);
		slot = (cmd_s1.op == obf_pkg::OP_WRITE) ? wr_base : rd_fix;
		if (slot >= dx) begin
			slot = slot - dx;
		end
		mem_addr = AW'(slot[SLW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DW'(DRST);
			overwrite_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			if (cfg_fire && cfg_index == obf_pkg::CFG_FIFO_DEPTH) begin
				// a depth change restarts both indices
				if (cfg_data == '0) begin
					depth_q <= DW'(1);
				end else if (cfg_data > DW'(DCAP)) begin
					depth_q <= DW'(DCAP);
				end else begin
					depth_q <= cfg_data;
				end
				wr_q <= '0;
				rd_q <= '0;
			end else if (valid_s1) begin
				wr_q <= wr_new;
				rd_q <= rd_new;
			end
			if (cfg_fire && cfg_index == obf_pkg::CFG_OVERWRITE_MODE) begin
				overwrite_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			ok_s2 <= ok_c;
			rdok_s2 <= mem_re;
			fixed_s2 <= fixed_c;
			fill_s2 <= fill_new[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cmd_s1.data_in;
		end
		if (mem_re) begin
			rdata_s2 <= mem[mem_addr];
		end
	end

	assign done = valid_s2;
	assign result = '{
		ok:             ok_s2,
		data_out:       (rdok_s2 ? rdata_s2 : 8'd0),
		fill_count:     fill_s2,
		overflow_fixed: fixed_s2
	};

	// every command transfer is followed by a result, after the command and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("command transfer without result");

	// indices stay inside the doubled range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (wr_q < two_d && rd_q < two_d))
		else $error("fifo index out of range");

	// a refused command returns neither data nor a re-placed read index
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ok) |-> (result.data_out == 8'd0 && !result.overflow_fixed))
		else $error("refused command carries data");

	// clear always succeeds and empties the fifo
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1.op == obf_pkg::OP_CLEAR && !cfg_fire)
		|=> (done && result.ok && result.fill_count == '0))
		else $error("clear did not empty the fifo");

	// overflow repair only on a read or peek that succeeded
	a_fix_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fixed_c) |-> (mem_re && ok_c))
		else $error("overflow repair outside a read");

endmodule
